[rtl/core/pstp_pkg.sv]
`timescale 1ns / 1ps

package pstp_pkg;

    // Input transaction: one speed sample
    typedef struct packed {
        logic signed [11:0] measured_speed;
        logic signed [15:0] target_speed;
    } t_in_item;

    // Output transaction: one PWM update
    typedef struct packed {
        logic        [13:0] duty_value;
        logic        [1:0]  drive_channel;
        logic        [1:0]  hold_channel;
        logic signed [15:0] correction;
    } t_out_item;

    // Configuration register indexes
    localparam logic [2:0] REG_KP_GAIN    = 3'd0;
    localparam logic [2:0] REG_KI_GAIN    = 3'd1;
    localparam logic [2:0] REG_SUM_LIMIT  = 3'd2;
    localparam logic [2:0] REG_OUT_LIMIT  = 3'd3;
    localparam logic [2:0] REG_BASE_SPEED = 3'd4;
    localparam logic [2:0] REG_MOTOR_SIDE = 3'd5;

    // Register reset values
    localparam logic [15:0]       KP_RESET    = 16'd20480;
    localparam logic [15:0]       KI_RESET    = 16'd1638;
    localparam logic [11:0]       SUML_RESET  = 12'd100;
    localparam logic [6:0]        OUTL_RESET  = 7'd68;
    localparam logic signed [7:0] BASE_RESET  = 8'sd24;
    localparam logic              SIDE_RESET  = 1'b1;

    // Duty scaling
    localparam logic signed [16:0] DUTY_SCALE = 17'sd125;
    localparam logic [13:0]        DUTY_MAX   = 14'd8500;

    // Timer channel numbers
    localparam logic [1:0] CH_LEFT_DRIVE  = 2'd3;
    localparam logic [1:0] CH_LEFT_HOLD   = 2'd2;
    localparam logic [1:0] CH_RIGHT_DRIVE = 2'd0;
    localparam logic [1:0] CH_RIGHT_HOLD  = 2'd1;

endpackage

[rtl/core/pi_speed_to_pwm.sv]
// PI speed loop for one motor. Each input transaction (measured speed in counts,
// target speed in Q12.4) updates the clamped error sum and yields one output
// transaction: the clamped PI correction in Q8.8 and a PWM compare value of
// (base_speed + correction) * 125, limited to 0..8500, with the drive and hold
// channel numbers picked by motor_side. One 18x17 signed multiplier is shared by the
// kp, ki and duty products under a six-state sequencer, and o_in_stall stays high
// while it runs, so no new sample is taken before the last one is through.
// A result waits in an output register; a stalled output holds the sequencer in
// its last step. Registers must be written only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps

module pi_speed_to_pwm
    import pstp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SUM   = 6'b000010,
        S_INT   = 6'b000100,
        S_CLAMP = 6'b001000,
        S_CORR  = 6'b010000,
        S_DUTY  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [15:0]       r_kp;
    logic [15:0]       r_ki;
    logic [11:0]       r_sum_limit;
    logic [6:0]        r_out_limit;
    logic signed [7:0] r_base;
    logic              r_side;

    // datapath registers
    logic signed [17:0] r_err;
    logic signed [17:0] r_sum;
    logic signed [35:0] r_acc;
    logic signed [23:0] r_pi;
    logic signed [15:0] r_corr;
    logic signed [17:0] r_v;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [17:0] w_err;
    logic signed [18:0] w_sum_raw;
    logic signed [18:0] w_sum_lim;
    logic signed [17:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [34:0] w_prod;
    logic signed [35:0] w_pi_lim;
    logic signed [23:0] w_pi_adj;
    logic signed [15:0] w_corr;
    logic [26:0]        w_duty_full;
    logic [13:0]        w_duty;
    logic               w_in_acc;
    logic               w_out_free;

    assign w_in_acc   = i_in_valid && r_state == S_IDLE;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // error in Q12.4: target - measured * 16
    assign w_err = 18'(i_in_data.target_speed) - (18'(i_in_data.measured_speed) <<< 4);

    // error sum update with symmetric clamp
    assign w_sum_raw = 19'(r_sum) + 19'(r_err);
    assign w_sum_lim = $signed({3'b000, r_sum_limit, 4'b0000});

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_SUM: begin
                w_mul_a = r_err;
                w_mul_b = $signed({1'b0, r_kp});
            end
            S_INT: begin
                w_mul_a = r_sum;
                w_mul_b = $signed({1'b0, r_ki});
            end
            default: begin
                w_mul_a = r_v;
                w_mul_b = DUTY_SCALE;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // PI clamp bound, out_limit in Q.16
    assign w_pi_lim = $signed({13'd0, r_out_limit, 16'd0});

    // Q.16 to Q8.8, truncating toward zero
    assign w_pi_adj = r_pi + (r_pi[23] ? 24'sd255 : 24'sd0);
    assign w_corr   = 16'(w_pi_adj >>> 8);

    // duty: (v * 125) >> 8, clamped to 0..8500
    assign w_duty_full = w_prod[34:8];
    always_comb begin
        if (r_v <= 18'sd0) begin
            w_duty = '0;
        end else if (w_duty_full > 27'(DUTY_MAX)) begin
            w_duty = DUTY_MAX;
        end else begin
            w_duty = 14'(w_duty_full);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SUM;
            S_SUM:   n_state = S_INT;
            S_INT:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_CORR;
            S_CORR:  n_state = S_DUTY;
            S_DUTY:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= KP_RESET;
            r_ki        <= KI_RESET;
            r_sum_limit <= SUML_RESET;
            r_out_limit <= OUTL_RESET;
            r_base      <= BASE_RESET;
            r_side      <= SIDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KP_GAIN:    r_kp        <= i_cfg_data;
                REG_KI_GAIN:    r_ki        <= i_cfg_data;
                REG_SUM_LIMIT:  r_sum_limit <= i_cfg_data[11:0];
                REG_OUT_LIMIT:  r_out_limit <= i_cfg_data[6:0];
                REG_BASE_SPEED: r_base      <= $signed(i_cfg_data[7:0]);
                REG_MOTOR_SIDE: r_side      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // error sum state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_state == S_SUM) begin
            if (w_sum_raw > w_sum_lim) begin
                r_sum <= 18'(w_sum_lim);
            end else if (w_sum_raw < -w_sum_lim) begin
                r_sum <= 18'(-w_sum_lim);
            end else begin
                r_sum <= 18'(w_sum_raw);
            end
        end
    end

    // datapath steps
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= w_err;
        end
        if (r_state == S_SUM) begin
            r_acc <= 36'(w_prod);
        end
        if (r_state == S_INT) begin
            r_acc <= r_acc + 36'(w_prod);
        end
        if (r_state == S_CLAMP) begin
            if (r_acc > w_pi_lim) begin
                r_pi <= 24'(w_pi_lim);
            end else if (r_acc < -w_pi_lim) begin
                r_pi <= 24'(-w_pi_lim);
            end else begin
                r_pi <= 24'(r_acc);
            end
        end
        if (r_state == S_CORR) begin
            r_corr <= w_corr;
            r_v    <= 18'($signed({r_base, 8'h00})) + 18'(w_corr);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DUTY && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DUTY && w_out_free) begin
            r_out.duty_value    <= w_duty;
            r_out.drive_channel <= r_side ? CH_LEFT_DRIVE : CH_RIGHT_DRIVE;
            r_out.hold_channel  <= r_side ? CH_LEFT_HOLD : CH_RIGHT_HOLD;
            r_out.correction    <= r_corr;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/pstp_checker.sv]
`timescale 1ns / 1ps

module pstp_checker
    import pstp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    // block is busy right after taking a sample
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again while a sample is in work");

    // duty stays in range
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.duty_value <= DUTY_MAX)
        else $error("duty value above limit");

    // channel pair is one of the two motor sides
    a_channel_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.drive_channel == CH_LEFT_DRIVE &&
             o_out_data.hold_channel == CH_LEFT_HOLD) ||
            (o_out_data.drive_channel == CH_RIGHT_DRIVE &&
             o_out_data.hold_channel == CH_RIGHT_HOLD))
        else $error("inconsistent drive and hold channels");

    // correction bounded by the largest out_limit
    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.correction <= 16'sd32512 &&
                        o_out_data.correction >= -16'sd32512)
        else $error("correction outside clamp range");

endmodule

bind pi_speed_to_pwm pstp_checker u_pstp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pstp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Tracks the speed loop state and the expected PWM updates
    class pi_loop_checker;
        logic        [15:0] kp;
        logic        [15:0] ki;
        logic        [11:0] sum_lim;
        logic        [6:0]  out_lim;
        logic signed [7:0]  base;
        logic               side;
        longint             err_sum;
        t_out_item          due_updates[$];
        int                 mismatches;

        function new();
            kp         = KP_RESET;
            ki         = KI_RESET;
            sum_lim    = SUML_RESET;
            out_lim    = OUTL_RESET;
            base       = BASE_RESET;
            side       = SIDE_RESET;
            err_sum    = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                REG_KP_GAIN:    kp = d;
                REG_KI_GAIN:    ki = d;
                REG_SUM_LIMIT:  sum_lim = d[11:0];
                REG_OUT_LIMIT:  out_lim = d[6:0];
                REG_BASE_SPEED: base = d[7:0];
                REG_MOTOR_SIDE: side = d[0];
                default: ;
            endcase
        endfunction

        function longint clamp_sym(longint x, longint lim);
            if (x > lim) return lim;
            if (x < -lim) return -lim;
            return x;
        endfunction

        // One speed sample in, one PWM update expected
        function void take_sample(t_in_item s);
            longint    meas;
            longint    targ;
            longint    err;
            longint    pi;
            longint    corr;
            longint    v;
            longint    duty;
            t_out_item r;
            meas    = longint'($signed(s.measured_speed));
            targ    = longint'($signed(s.target_speed));
            err     = targ - meas * 16;
            err_sum = clamp_sym(err_sum + err, longint'(sum_lim) * 16);
            pi      = longint'(kp) * err + longint'(ki) * err_sum;
            pi      = clamp_sym(pi, longint'(out_lim) * 65536);
            corr    = pi / 256;
            v       = longint'(base) * 256 + corr;
            if (v <= 0) begin
                duty = 0;
            end else begin
                duty = (v * 125) / 256;
                if (duty > 8500) duty = 8500;
            end
            r.duty_value    = duty[13:0];
            r.drive_channel = side ? CH_LEFT_DRIVE : CH_RIGHT_DRIVE;
            r.hold_channel  = side ? CH_LEFT_HOLD : CH_RIGHT_HOLD;
            r.correction    = corr[15:0];
            due_updates.push_back(r);
        endfunction

        function void check_update(t_out_item got);
            t_out_item want;
            if (due_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected PWM update: duty=%0d drv=%0d hold=%0d corr=%0d",
                             got.duty_value, got.drive_channel, got.hold_channel,
                             got.correction);
                return;
            end
            want = due_updates.pop_front();
            if (got.duty_value !== want.duty_value || got.drive_channel !== want.drive_channel
                || got.hold_channel !== want.hold_channel
                || got.correction !== want.correction) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp duty=%0d drv=%0d hold=%0d corr=%0d, got duty=%0d drv=%0d hold=%0d corr=%0d",
                             want.duty_value, want.drive_channel, want.hold_channel,
                             want.correction, got.duty_value, got.drive_channel,
                             got.hold_channel, got.correction);
            end
        endfunction

        function int pending();
            return due_updates.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    pi_loop_checker chk;
    bit             rx_go    = 1'b0;
    bit             no_idle  = 1'b0;
    bit             hold_req = 1'b0;
    int             cycles   = 0;

    pi_speed_to_pwm DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic t_in_item mk(int m, int t);
        t_in_item r;
        r.measured_speed = m[11:0];
        r.target_speed   = t[15:0];
        return r;
    endfunction

    // Mostly near-tracking samples so the sum and correction stay unsaturated
    function automatic t_in_item rand_sample();
        int m;
        int t;
        case ($urandom_range(0, 9))
            0: begin
                m = $urandom_range(0, 1) ? 2047 : -2048;
                t = $urandom_range(0, 1) ? 32767 : -32768;
            end
            1, 2: begin
                m = int'($urandom);
                t = int'($urandom);
            end
            default: begin
                m = int'($urandom_range(0, 4095)) - 2048;
                t = m * 16 + int'($urandom_range(0, 255)) - 128;
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
            end
        endcase
        return mk(m, t);
    endfunction

    function automatic logic [15:0] pick_field(int w);
        logic [15:0] ones;
        ones = 16'((32'd1 << w) - 1);
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return ones;
            2: return 16'($urandom_range(0, 255)) & ones;
            default: return 16'($urandom) & ones;
        endcase
    endfunction

    function automatic logic [15:0] pick_base();
        case ($urandom_range(0, 3))
            0: return 16'h0080;
            1: return 16'h007F;
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one sample after a random gap; valid stays high into the next call
    task automatic send_sample(input t_in_item s);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        chk.take_sample(s);
    endtask

    // Wait until the block is idle again
    task automatic drain();
        i_in_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write every register, plus the unused indexes with random data
    task automatic load_settings(input logic [15:0] kp, ki, sl, ol, bs, sd);
        logic [15:0] vals [8];
        logic [15:0] d;
        vals[REG_KP_GAIN]    = kp;
        vals[REG_KI_GAIN]    = ki;
        vals[REG_SUM_LIMIT]  = sl;
        vals[REG_OUT_LIMIT]  = ol;
        vals[REG_BASE_SPEED] = bs;
        vals[REG_MOTOR_SIDE] = sd;
        for (int i = 0; i < 8; i++) begin
            d = (i > REG_MOTOR_SIDE) ? 16'($urandom) : vals[i];
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= d;
            @(posedge i_clk);
            chk.set_reg(3'(i), d);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, one long hold on request
    initial begin
        int n;
        wait (rx_go);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n = 300;
            end else begin
                n = draw_gap();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            chk.check_update(o_out_data);
        end
    end

    initial begin
        chk = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_go = 1'b1;

        // Reset settings: field extremes, large errors both ways, zero error
        send_sample(mk(0, 0));
        send_sample(mk(2047, 32767));
        send_sample(mk(-2048, -32768));
        send_sample(mk(-2048, 32767));
        send_sample(mk(2047, -32768));
        send_sample(mk(0, 32767));
        send_sample(mk(0, -32768));
        send_sample(mk(2047, 0));
        send_sample(mk(-2048, 0));
        send_sample(mk(100, 1600));
        send_sample(mk(1, 0));
        send_sample(mk(0, 1));
        drain();

        // Largest gains and limits, right motor
        load_settings(16'hFFFF, 16'hFFFF, 16'd4095, 16'd127, 16'h007F, 16'd0);
        send_sample(mk(-2048, 32767));
        send_sample(mk(2047, -32768));
        send_sample(mk(0, 0));
        send_sample(mk(10, 100));
        drain();

        // Zero limits and gains, most negative base: duty pinned at zero
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'h0080, 16'd1);
        send_sample(mk(5, -3));
        send_sample(mk(-2048, 32767));
        drain();

        // Zero limits with live gains, duty from base alone and clamped high
        load_settings(16'd20480, 16'd1638, 16'd0, 16'd0, 16'h007F, 16'd0);
        send_sample(mk(300, -32768));
        send_sample(mk(0, 5));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            load_settings(pick_field(16), pick_field(16), pick_field(12), pick_field(7),
                          pick_base(), 16'($urandom_range(0, 1)));
            no_idle = (ph == 2) || ($urandom_range(0, 3) == 0);
            if (ph == 1) hold_req = 1'b1;
            repeat (100) send_sample(rand_sample());
            drain();
        end
        repeat (12) @(posedge i_clk);

        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pstp_pkg.sv
rtl/core/pi_speed_to_pwm.sv
rtl/core/pstp_checker.sv
tb/tb.sv
